// File: rtl/core/sfr_pkg.sv
package sfr_pkg;

    localparam int POS_W  = 7;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 5;
    localparam int IDLE_W = 17;
    localparam int CFG_W  = 16;
    localparam int TIMEOUT_W = 16;

    localparam int HEADER_BYTES = 4;
    localparam int RESULT_CAP   = 32;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT       = 2'd3;

    localparam logic [7:0]           RST_HEADER_FIRST  = 8'd170;
    localparam logic [7:0]           RST_HEADER_SECOND = 8'd85;
    localparam logic [LEN_W-1:0]     RST_MAX_LENGTH    = 6'd32;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT       = 16'd1000;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic rd_start;
        logic load_rec;
        logic next_rec;
    } sfr_cmd_t;

    typedef struct packed {
        logic emit;
        logic rec_last;
    } sfr_status_t;

endpackage

// File: rtl/core/sfr_ram.sv
module sfr_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sfr_datapath.sv
module sfr_datapath
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 32,
    parameter int FRAME_LIMIT   = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               in_mode,
    input  logic [7:0]         in_byte,
    input  sfr_cmd_t           cmd,
    output sfr_status_t        status,
    output logic [1:0]         result_kind,
    output logic               healthy,
    output logic [7:0]         frame_id,
    output logic [LEN_W-1:0]   frame_length,
    output logic [IDX_W-1:0]   payload_index,
    output logic [7:0]         payload_byte,
    output logic               last
);

    localparam int AW  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CAP = (PAYLOAD_BYTES < RESULT_CAP) ? PAYLOAD_BYTES : RESULT_CAP;
    localparam logic [7:0] CAP_B         = 8'(CAP);
    localparam logic [7:0] FRAME_LIMIT_B = 8'(FRAME_LIMIT);
    localparam logic [7:0] HEADER_B      = 8'(HEADER_BYTES);

    logic [7:0]           hdr_first_reg;
    logic [7:0]           hdr_second_reg;
    logic [LEN_W-1:0]     max_len_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic                 mode_reg;
    logic [7:0]           byte_reg;

    logic [POS_W-1:0]     pos_reg,     pos_next;
    logic [7:0]           id_reg,      id_next;
    logic [LEN_W-1:0]     len_reg,     len_next;
    logic                 healthy_reg, healthy_next;
    logic [IDLE_W-1:0]    idle_reg,    idle_next;

    logic [7:0]           em_id_reg;
    logic [LEN_W-1:0]     em_len_reg;
    logic [IDX_W-1:0]     idx_reg,     idx_next;

    logic [1:0]           kind_reg;
    logic                 out_healthy_reg;
    logic [7:0]           out_id_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic [7:0]           limit;
    logic [7:0]           pos_b;
    logic [7:0]           end_b;
    logic [7:0]           pos_inc;
    logic [IDLE_W-1:0]    idle_inc;
    logic                 complete;
    logic                 advance;
    logic                 restart;
    logic                 ram_wr_en;
    logic [7:0]           ram_rd_data;

    assign limit   = (max_len_reg < CAP_B[LEN_W-1:0]) ? {2'b00, max_len_reg} : CAP_B;
    assign pos_b   = {1'b0, pos_reg};
    assign end_b   = {2'b00, len_reg} + HEADER_B;
    assign pos_inc = pos_b + 8'd1;
    assign idle_inc = (idle_reg == {IDLE_W{1'b1}}) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        pos_next     = pos_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        healthy_next = healthy_reg;
        idle_next    = idle_reg;
        complete     = 1'b0;
        advance      = 1'b0;
        restart      = 1'b0;
        ram_wr_en    = 1'b0;
        if (cmd.exec)
        begin
            if (mode_reg)
            begin
                idle_next = idle_inc;
                if (idle_inc > {1'b0, timeout_reg})
                begin
                    healthy_next = 1'b0;
                end
            end
            else
            begin
                idle_next = '0;
                if (pos_b == 8'd0)
                begin
                    advance = (byte_reg == hdr_first_reg);
                end
                else if (pos_b == 8'd1)
                begin
                    if (byte_reg != hdr_second_reg)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
                else if (pos_b == 8'd2)
                begin
                    id_next = byte_reg;
                    advance = 1'b1;
                end
                else if (pos_b == 8'd3)
                begin
                    if (byte_reg > limit)
                    begin
                        restart = 1'b1;
                    end
                    else
                    begin
                        len_next = byte_reg[LEN_W-1:0];
                        advance  = 1'b1;
                    end
                end
                else if (pos_b < end_b)
                begin
                    ram_wr_en = 1'b1;
                    advance   = 1'b1;
                end
                else if (pos_b == end_b)
                begin
                    healthy_next = 1'b1;
                    complete     = 1'b1;
                    restart      = 1'b1;
                end
                else
                begin
                    advance = 1'b1;
                end
                if (advance)
                begin
                    if (pos_inc > FRAME_LIMIT_B)
                    begin
                        restart = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                end
                if (restart)
                begin
                    pos_next = '0;
                    id_next  = '0;
                    len_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.rd_start)
        begin
            idx_next = '0;
        end
        else if (cmd.next_rec)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    assign status.emit     = complete && (len_reg != '0);
    assign status.rec_last = out_last_reg;

    sfr_ram
    #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_BYTES)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(pos_b - HEADER_B)),
        .wr_data (byte_reg),
        .rd_addr (AW'(idx_next)),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= RST_HEADER_FIRST;
            hdr_second_reg <= RST_HEADER_SECOND;
            max_len_reg    <= RST_MAX_LENGTH;
            timeout_reg    <= RST_TIMEOUT;
            pos_reg        <= '0;
            id_reg         <= '0;
            len_reg        <= '0;
            healthy_reg    <= 1'b1;
            idle_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_HEADER_FIRST:  hdr_first_reg  <= cfg_wr_data[7:0];
                    REG_HEADER_SECOND: hdr_second_reg <= cfg_wr_data[7:0];
                    REG_MAX_LENGTH:    max_len_reg    <= cfg_wr_data[LEN_W-1:0];
                    REG_TIMEOUT:       timeout_reg    <= cfg_wr_data[TIMEOUT_W-1:0];
                    default:           ;
                endcase
            end
            pos_reg     <= pos_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            healthy_reg <= healthy_next;
            idle_reg    <= idle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load_item)
        begin
            mode_reg <= in_mode;
            byte_reg <= in_byte;
        end
        if (cmd.exec)
        begin
            em_id_reg       <= id_reg;
            em_len_reg      <= len_reg;
            kind_reg        <= complete ? KIND_EMPTY : KIND_STATUS;
            out_healthy_reg <= healthy_next;
            out_id_reg      <= complete ? id_reg : 8'd0;
            out_len_reg     <= '0;
            out_idx_reg     <= '0;
            out_byte_reg    <= '0;
            out_last_reg    <= 1'b1;
        end
        else if (cmd.load_rec)
        begin
            kind_reg        <= KIND_RECORD;
            out_healthy_reg <= healthy_reg;
            out_id_reg      <= em_id_reg;
            out_len_reg     <= em_len_reg;
            out_idx_reg     <= idx_reg;
            out_byte_reg    <= ram_rd_data;
            out_last_reg    <= (({1'b0, idx_reg} + 1'b1) == em_len_reg);
        end
    end

    assign result_kind   = kind_reg;
    assign healthy       = out_healthy_reg;
    assign frame_id      = out_id_reg;
    assign frame_length  = out_len_reg;
    assign payload_index = out_idx_reg;
    assign payload_byte  = out_byte_reg;
    assign last          = out_last_reg;

endmodule

// File: rtl/core/sfr_ctrl.sv
module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  sfr_status_t status,
    output sfr_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.emit)
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = ST_READ;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_READ:
            begin
                cmd.load_rec = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (status.rec_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_rec = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/serial_frame_receiver_top.sv
// Frame receiver for a byte stream framed as two header bytes, an id, a length, that many
// payload bytes and a check byte (not verified). Each input word is either a received byte
// or a millisecond tick. Every tick, and every byte that does not end a frame, returns one
// status word; the check byte returns one word per payload byte, or a single empty-frame
// word when the length is zero, with tlast on the final word. One word is handled at a
// time: a tick or ordinary byte passes through an execute and an output state, and a
// completing frame through the execute state and then a read and an output state per
// record, waiting in each output state while the output is stalled; the read state is
// needed as the payload RAM has a single registered read port. The next word is accepted
// once the last result word has been taken. The payload RAM is not cleared.
module serial_frame_receiver_top
    import sfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 32,
    parameter int FRAME_LIMIT   = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // byte_value
    input  logic             s_tuser,     // mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,     // healthy, frame_id, frame_length, payload_index,
                                          // payload_byte, zero fill
    output logic [1:0]       m_tuser,     // result_kind
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    sfr_cmd_t         cmd;
    sfr_status_t      status;
    logic             healthy;
    logic [7:0]       frame_id;
    logic [LEN_W-1:0] frame_length;
    logic [IDX_W-1:0] payload_index;
    logic [7:0]       payload_byte;

    sfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfr_datapath
    #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .FRAME_LIMIT   (FRAME_LIMIT)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .in_mode       (s_tuser),
        .in_byte       (s_tdata),
        .cmd           (cmd),
        .status        (status),
        .result_kind   (m_tuser),
        .healthy       (healthy),
        .frame_id      (frame_id),
        .frame_length  (frame_length),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .last          (m_tlast)
    );

    assign m_tdata = {4'd0, payload_byte, payload_index, frame_length, frame_id, healthy};

`ifndef SYNTH
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output handshakes open together");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("word accepted without a processing cycle");

    a_record_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !s_tready && (m_tuser == KIND_RECORD))
        else $error("record run broken before its last word");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_STATUS || m_tuser == KIND_EMPTY) |-> m_tlast)
        else $error("single result word without tlast");
`endif

endmodule
